// ===== rtl/lmcs_pkg.sv =====
// Package for the LED matrix column scanner.
// Holds item structs, command and phase codes, and parameter defaults.
// No dependencies.
package lmcs_pkg;

	localparam int COLUMNS_PER_COLOUR_DEF = 16;
	localparam int ROW_BITS_DEF           = 8;
	localparam int TOTAL_COLUMNS          = 32;

	typedef enum logic [1:0] {
		CMD_TICK        = 2'd0,
		CMD_WRITE_RED   = 2'd1,
		CMD_WRITE_GREEN = 2'd2,
		CMD_CLEAR_DONE  = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		PH_LINES_LOW   = 3'd0,
		PH_RESET_RAISE = 3'd1,
		PH_RESET_WAIT  = 3'd2,
		PH_FRAME_START = 3'd3,
		PH_NEXT_COLUMN = 3'd4,
		PH_CLOCK_HIGH  = 3'd5,
		PH_LED_HOLD    = 3'd6,
		PH_RESET_HIGH  = 3'd7
	} phase_t;

	// clock line bits
	localparam int CK1 = 0;
	localparam int CK2 = 1;
	localparam int CK3 = 2;
	localparam int CK4 = 3;

	typedef struct packed {
		logic [1:0] command;
		logic       timer_event;
		logic [3:0] entry_index;
		logic [7:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [7:0] row_pattern;
		logic       counter_clock_1;
		logic       counter_clock_2;
		logic       counter_clock_3;
		logic       counter_clock_4;
		logic       matrix_reset;
		logic       frame_done;
	} rsp_t;

endpackage

// ===== rtl/led_matrix_column_scanner.sv =====
// LED matrix column scanner: the result is valid in the cycle after item accept.
// Throughput 1 item per cycle when not stalled; every item yields one result, taken from the
// state right after that item's update. The result register stalls the input
// only when it is full and stalled itself. Depends on lmcs_pkg.
// Reset (arst_n low, async): sequencer in lines-low phase, all lines low,
// column 0, all pending and shown stores zero, no result held.
module led_matrix_column_scanner #(
	parameter int COLUMNS_PER_COLOUR = lmcs_pkg::COLUMNS_PER_COLOUR_DEF,
	parameter int ROW_BITS           = lmcs_pkg::ROW_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lmcs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lmcs_pkg::rsp_t rsp
);

	// Only 8 row bits ever enter or leave, so stores are at most 8 bits wide.
	localparam int RW  = (ROW_BITS < 8) ? ROW_BITS : 8;
	localparam int CIW = $clog2(COLUMNS_PER_COLOUR);

	// ---------------- state ----------------
	lmcs_pkg::phase_t phase_q, phase_d;
	logic [5:0]       col_q, col_d;
	logic             timer_q, timer_d;
	logic [RW-1:0]    row_q, row_d;
	logic [3:0]       clk_lv_q, clk_lv_d;
	logic             rst_lv_q, rst_lv_d;
	logic             done_q, done_d;
	logic             copy;

	logic [RW-1:0] pend_red_q [COLUMNS_PER_COLOUR];
	logic [RW-1:0] pend_grn_q [COLUMNS_PER_COLOUR];
	logic [RW-1:0] show_red_q [COLUMNS_PER_COLOUR];
	logic [RW-1:0] show_grn_q [COLUMNS_PER_COLOUR];

	logic           out_valid_q;
	lmcs_pkg::rsp_t out_q;

	logic     accept;
	logic     tick;
	logic     tp;          // timer flag including this tick's event
	logic     wr_ok;
	logic [4:0]    half;
	logic [CIW-1:0] slot;
	logic [RW-1:0] shown_val;

	// Input is held back only while a result is waiting and stalled.
	assign req_stall = out_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign tick      = accept && (req.command == lmcs_pkg::CMD_TICK);
	assign tp        = timer_q | req.timer_event;
	assign wr_ok     = ({1'b0, req.entry_index} < 5'(COLUMNS_PER_COLOUR));

	// Slot shown for the current column: even columns red, odd columns green,
	// counting down from the last slot; columns whose pair index reaches the colour size show 0.
	assign half = col_q[5:1];
	assign slot = CIW'(COLUMNS_PER_COLOUR - 1) - half[CIW-1:0];
	always_comb begin
		if (half >= 5'(COLUMNS_PER_COLOUR)) begin
			shown_val = '0;
		end else if (col_q[0]) begin
			shown_val = show_grn_q[slot];
		end else begin
			shown_val = show_red_q[slot];
		end
	end

	// ---------------- sequencer next phase ----------------
	always_comb begin
		phase_d = phase_q;
		if (tick) begin
			case (phase_q)
				lmcs_pkg::PH_LINES_LOW:   phase_d = lmcs_pkg::PH_RESET_RAISE;
				lmcs_pkg::PH_RESET_RAISE: phase_d = lmcs_pkg::PH_RESET_WAIT;
				lmcs_pkg::PH_RESET_WAIT:  if (tp) phase_d = lmcs_pkg::PH_FRAME_START;
				lmcs_pkg::PH_FRAME_START: phase_d = lmcs_pkg::PH_CLOCK_HIGH;
				lmcs_pkg::PH_CLOCK_HIGH:  if (tp) phase_d = lmcs_pkg::PH_LED_HOLD;
				lmcs_pkg::PH_LED_HOLD:    if (tp) phase_d = lmcs_pkg::PH_NEXT_COLUMN;
				lmcs_pkg::PH_NEXT_COLUMN: begin
					if (tp) begin
						if (col_q < 6'(lmcs_pkg::TOTAL_COLUMNS)) begin
							phase_d = lmcs_pkg::PH_CLOCK_HIGH;
						end else begin
							phase_d = lmcs_pkg::PH_RESET_HIGH;
						end
					end
				end
				lmcs_pkg::PH_RESET_HIGH:  if (tp) phase_d = lmcs_pkg::PH_FRAME_START;
				default:                  phase_d = phase_q;
			endcase
		end
	end

	// ---------------- sequencer line and counter updates ----------------
	always_comb begin
		col_d    = col_q;
		timer_d  = timer_q;
		row_d    = row_q;
		clk_lv_d = clk_lv_q;
		rst_lv_d = rst_lv_q;
		done_d   = done_q;
		copy     = 1'b0;
		if (accept && (req.command == lmcs_pkg::CMD_CLEAR_DONE)) begin
			done_d = 1'b0;
		end
		if (tick) begin
			timer_d = tp;
			case (phase_q)
				lmcs_pkg::PH_LINES_LOW: clk_lv_d = '0;
				lmcs_pkg::PH_RESET_RAISE: begin
					rst_lv_d = 1'b1;
					timer_d  = 1'b0;
				end
				lmcs_pkg::PH_RESET_WAIT: if (tp) rst_lv_d = 1'b0;
				lmcs_pkg::PH_FRAME_START: begin
					col_d              = '0;
					copy               = 1'b1;
					timer_d            = 1'b0;
					clk_lv_d[lmcs_pkg::CK3] = 1'b1;
				end
				lmcs_pkg::PH_CLOCK_HIGH: begin
					if (tp) begin
						timer_d  = 1'b0;
						row_d    = shown_val;
						col_d    = col_q + 6'd1;
						rst_lv_d = 1'b0;
						clk_lv_d = '0;
					end
				end
				lmcs_pkg::PH_LED_HOLD: if (tp) timer_d = 1'b0;
				lmcs_pkg::PH_NEXT_COLUMN: begin
					if (tp) begin
						timer_d = 1'b0;
						row_d   = '0;
						if (col_q < 6'(lmcs_pkg::TOTAL_COLUMNS)) begin
							// boundary columns also re-raise the previous clock
							if ((col_q > 6'd0 && col_q <= 6'd7) || col_q == 6'd8)
								clk_lv_d[lmcs_pkg::CK3] = 1'b1;
							if ((col_q > 6'd7 && col_q <= 6'd15) || col_q == 6'd16)
								clk_lv_d[lmcs_pkg::CK4] = 1'b1;
							if ((col_q > 6'd15 && col_q <= 6'd23) || col_q == 6'd24)
								clk_lv_d[lmcs_pkg::CK1] = 1'b1;
							if (col_q > 6'd23 && col_q <= 6'd31)
								clk_lv_d[lmcs_pkg::CK2] = 1'b1;
						end else begin
							done_d   = 1'b1;
							rst_lv_d = 1'b1;
						end
					end
				end
				lmcs_pkg::PH_RESET_HIGH: begin
					if (tp) begin
						timer_d  = 1'b0;
						rst_lv_d = 1'b0;
					end
				end
				default: timer_d = tp;
			endcase
		end
	end

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lmcs_pkg::PH_LINES_LOW;
			col_q    <= '0;
			timer_q  <= 1'b0;
			row_q    <= '0;
			clk_lv_q <= '0;
			rst_lv_q <= 1'b0;
			done_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			col_q    <= col_d;
			timer_q  <= timer_d;
			row_q    <= row_d;
			clk_lv_q <= clk_lv_d;
			rst_lv_q <= rst_lv_d;
			done_q   <= done_d;
		end
	end

	// Pending stores take writes; shown stores copy them at frame start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLUMNS_PER_COLOUR; i++) begin
				pend_red_q[i] <= '0;
				pend_grn_q[i] <= '0;
				show_red_q[i] <= '0;
				show_grn_q[i] <= '0;
			end
		end else if (accept) begin
			if (req.command == lmcs_pkg::CMD_WRITE_RED && wr_ok)
				pend_red_q[req.entry_index[CIW-1:0]] <= req.entry_value[RW-1:0];
			if (req.command == lmcs_pkg::CMD_WRITE_GREEN && wr_ok)
				pend_grn_q[req.entry_index[CIW-1:0]] <= req.entry_value[RW-1:0];
			if (copy) begin
				for (int i = 0; i < COLUMNS_PER_COLOUR; i++) begin
					show_red_q[i] <= pend_red_q[i];
					show_grn_q[i] <= pend_grn_q[i];
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.row_pattern     <= 8'(row_d);
			out_q.counter_clock_1 <= clk_lv_d[lmcs_pkg::CK1];
			out_q.counter_clock_2 <= clk_lv_d[lmcs_pkg::CK2];
			out_q.counter_clock_3 <= clk_lv_d[lmcs_pkg::CK3];
			out_q.counter_clock_4 <= clk_lv_d[lmcs_pkg::CK4];
			out_q.matrix_reset    <= rst_lv_d;
			out_q.frame_done      <= done_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	// A lit row only exists between clock-high and the next blanking.
	a_row_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q != '0) |-> (phase_q == lmcs_pkg::PH_LED_HOLD ||
			phase_q == lmcs_pkg::PH_NEXT_COLUMN))
		else $error("row driven outside LED hold window");

	// Counter reset line is high only in the reset-wait and reset-high phases.
	a_reset_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rst_lv_q |-> (phase_q == lmcs_pkg::PH_RESET_WAIT ||
			phase_q == lmcs_pkg::PH_RESET_HIGH))
		else $error("matrix reset high in wrong phase");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= 6'(lmcs_pkg::TOTAL_COLUMNS))
		else $error("column count past frame end");

	// Every accepted item leaves a result behind.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted item produced no result");
`endif

endmodule
